// ===== rtl/ppc_pkg.sv =====
// package: shared types and constants of the pulse/period capture block
`default_nettype none

package ppc_pkg;

  typedef enum logic [1:0] {
    FUNC_EDGE  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_REARM = 2'd2
  } func_e;

  localparam logic [1:0] PHASE_ONE   = 2'd1;
  localparam logic [1:0] PHASE_TWO   = 2'd2;
  localparam logic [1:0] PHASE_THREE = 2'd3;

  localparam logic [1:0] TALLY_ONE = 2'd1;
  localparam logic [1:0] TALLY_MAX = 2'd2;

  localparam logic REG_EDGE_MODE  = 1'b0;
  localparam logic REG_START_EDGE = 1'b1;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic edge_mode;
    logic start_edge;
    logic start_wr;
    logic start_wdata;
  } cfg_t;

  typedef struct packed {
    logic        captured;
    logic        overrange;
    logic [15:0] high_count;
    logic [15:0] low_count;
    logic [15:0] period_count;
    logic [1:0]  edge_phase;
    logic        expect_falling;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/ppc_if.sv =====
// stream interfaces: event requests in, measurement results out
`default_nettype none

interface ppc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] timestamp;

  modport source (output valid, output func, output timestamp, input ready);
  modport sink   (input valid, input func, input timestamp, output ready);
endinterface

interface ppc_out_if;
  logic        valid;
  logic        ready;
  logic        captured;
  logic        overrange;
  logic [15:0] high_count;
  logic [15:0] low_count;
  logic [15:0] period_count;
  logic [1:0]  edge_phase;
  logic        expect_falling;

  modport source (
    output valid, output captured, output overrange, output high_count,
    output low_count, output period_count, output edge_phase, output expect_falling,
    input ready
  );
  modport sink (
    input valid, input captured, input overrange, input high_count,
    input low_count, input period_count, input edge_phase, input expect_falling,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/ppc_cfg.sv =====
// apb configuration registers: edge mode and start edge polarity
`default_nettype none

module ppc_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output ppc_pkg::cfg_t    cfg_o
);
  import ppc_pkg::*;

  logic edge_mode_q, edge_mode_d;
  logic start_edge_q, start_edge_d;
  logic wr_en;
  logic sel_bit;

  assign wr_en   = psel && penable && pwrite;
  assign sel_bit = paddr[2];
  assign pready  = 1'b1;

  always_comb begin
    edge_mode_d  = edge_mode_q;
    start_edge_d = start_edge_q;
    if (wr_en) begin
      case (sel_bit)
        REG_EDGE_MODE:  edge_mode_d  = pwdata[0];
        REG_START_EDGE: start_edge_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_mode_q  <= 1'b0;
      start_edge_q <= 1'b0;
    end else begin
      edge_mode_q  <= edge_mode_d;
      start_edge_q <= start_edge_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (sel_bit)
      REG_EDGE_MODE:  prdata[0] = edge_mode_q;
      REG_START_EDGE: prdata[0] = start_edge_q;
      default: ;
    endcase
  end

  assign cfg_o.edge_mode   = edge_mode_q;
  assign cfg_o.start_edge  = start_edge_q;
  assign cfg_o.start_wr    = wr_en && (sel_bit == REG_START_EDGE);
  assign cfg_o.start_wdata = pwdata[0];

endmodule

`default_nettype wire

// ===== rtl/ppc_state.sv =====
// measurement state and its update for one event
`default_nettype none

module ppc_state #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ppc_pkg::cfg_t   cfg_i,
  input  wire logic            fire_i,
  input  wire logic [1:0]      func_i,
  input  wire logic [15:0]     timestamp_i,
  output ppc_pkg::result_t     result_o
);
  import ppc_pkg::*;

  localparam int unsigned SW = (TIMER_BITS < 16) ? TIMER_BITS : 16;
  localparam int unsigned XW = (TIMER_BITS + 2 > 17) ? TIMER_BITS + 2 : 17;
  localparam logic [XW-1:0] TMOD  = XW'(1) << TIMER_BITS;
  localparam logic [XW-1:0] TMASK = TMOD - XW'(1);

  logic [SW-1:0] first_q, first_d;
  logic [SW-1:0] second_q, second_d;
  logic [1:0]    phase_q, phase_d;
  logic          pol_q, pol_d;
  logic          done_q, done_d;
  logic [1:0]    tally_q, tally_d;
  logic [15:0]   high_q, high_d;
  logic [15:0]   low_q, low_d;
  logic          ovr_q, ovr_d;

  logic [1:0]    ph_eff;
  logic          idle;
  logic [SW-1:0] stamp;
  logic [SW-1:0] prev_stamp;
  logic [XW-1:0] raw;
  logic [XW-1:0] diff;
  logic [15:0]   interval;
  logic [15:0]   hi, lo;
  logic [16:0]   per;
  func_e         func;

  assign func   = func_e'(func_i);
  assign ph_eff = (phase_q == 2'd0) ? PHASE_ONE : phase_q;
  assign idle   = done_q || ovr_q;
  assign stamp  = timestamp_i[SW-1:0];
  assign prev_stamp = (ph_eff == PHASE_TWO) ? first_q : second_q;

  // wrap-corrected difference, one timer wrap at most
  always_comb begin
    raw = ((tally_q != 2'd0) ? TMOD : '0) + XW'(stamp) - XW'(prev_stamp);
    diff = (tally_q != 2'd0) ? raw : (raw & TMASK);
    interval = (|diff[XW-1:16]) ? COUNT_MAX : diff[15:0];
  end

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    phase_d  = phase_q;
    pol_d    = pol_q;
    done_d   = done_q;
    tally_d  = tally_q;
    high_d   = high_q;
    low_d    = low_q;
    ovr_d    = ovr_q;

    if (cfg_i.start_wr && (phase_q <= PHASE_ONE)) begin
      pol_d = cfg_i.start_wdata;
    end

    if (fire_i) begin
      case (func)
        FUNC_EDGE: begin
          if (!idle) begin
            case (ph_eff)
              PHASE_TWO: begin
                second_d = stamp;
                // awaited polarity falling means the first edge was rising
                high_d = pol_q ? interval : '0;
                low_d  = pol_q ? '0 : interval;
                if (!cfg_i.edge_mode) begin
                  done_d  = 1'b1;
                  phase_d = PHASE_ONE;
                end else begin
                  phase_d = PHASE_THREE;
                end
              end
              PHASE_THREE: begin
                if (pol_q) high_d = interval;
                else       low_d  = interval;
                done_d  = 1'b1;
                phase_d = PHASE_ONE;
              end
              default: begin
                first_d = stamp;
                phase_d = PHASE_TWO;
              end
            endcase
            tally_d = '0;
            pol_d   = ~pol_q;
          end
        end
        FUNC_TICK: begin
          if (!idle && (phase_q > PHASE_ONE)) begin
            if (tally_q >= TALLY_ONE) begin
              tally_d = TALLY_MAX;
              ovr_d   = 1'b1;
              high_d  = '0;
              low_d   = '0;
              phase_d = PHASE_ONE;
              pol_d   = cfg_i.start_edge;
            end else begin
              tally_d = TALLY_ONE;
            end
          end
        end
        FUNC_REARM: begin
          first_d  = '0;
          second_d = '0;
          phase_d  = PHASE_ONE;
          pol_d    = cfg_i.start_edge;
          done_d   = 1'b0;
          tally_d  = '0;
          high_d   = '0;
          low_d    = '0;
          ovr_d    = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      phase_q  <= PHASE_ONE;
      pol_q    <= 1'b0;
      done_q   <= 1'b0;
      tally_q  <= '0;
      high_q   <= '0;
      low_q    <= '0;
      ovr_q    <= 1'b0;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      phase_q  <= phase_d;
      pol_q    <= pol_d;
      done_q   <= done_d;
      tally_q  <= tally_d;
      high_q   <= high_d;
      low_q    <= low_d;
      ovr_q    <= ovr_d;
    end
  end

  assign hi  = done_d ? high_d : '0;
  assign lo  = done_d ? low_d : '0;
  assign per = {1'b0, hi} + {1'b0, lo};

  assign result_o.captured       = done_d;
  assign result_o.overrange      = ovr_d;
  assign result_o.high_count     = hi;
  assign result_o.low_count      = lo;
  assign result_o.period_count   = per[16] ? COUNT_MAX : per[15:0];
  assign result_o.edge_phase     = (phase_d == 2'd0) ? PHASE_ONE : phase_d;
  assign result_o.expect_falling = pol_d;

endmodule

`default_nettype wire

// ===== rtl/pulse_period_capture.sv =====
// top level of the pulse/period capture block
// usage:
//   req_i carries events: func selects captured edge (with its timer stamp),
//   timer overflow tick or rearm. each accepted request yields exactly one
//   result on res_o: captured/overrange flags, high, low and period counts of
//   the held measurement, the next awaited edge number and its polarity.
//   apb port: register 0 at address 0 is edge_mode (pulse or period),
//   register 1 at address 4 is start_edge; write only while no request is in
//   flight. pready is tied high, reads return the register value.
// pipeline:
//   a request waits in the input register until the result register can
//   take it, then is folded into the state as its result is registered.
//   one request per cycle is sustained while res_o.ready stays high.
// reset:
//   asynchronous active low; clears the pipeline valid flags, the measurement
//   state (phase 1, awaited polarity rising) and the configuration registers.
// stalls:
//   while res_o.ready is low the result holds and one more request can wait in
//   the input register; req_i.ready drops only when both are full.
`default_nettype none

module pulse_period_capture #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ppc_in_if.sink           req_i,
  ppc_out_if.source        res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ppc_pkg::*;

  cfg_t        cfg;
  result_t     res_d, res_q;
  logic        in_vld_q;
  logic [1:0]  in_func_q;
  logic [15:0] in_ts_q;
  logic        out_vld_q;
  logic        adv;
  logic        fire;

  assign adv   = !out_vld_q || res_o.ready;
  assign fire  = in_vld_q && adv;
  assign req_i.ready = !in_vld_q || adv;

  ppc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppc_state #(
    .TIMER_BITS (TIMER_BITS)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (fire),
    .func_i      (in_func_q),
    .timestamp_i (in_ts_q),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (req_i.ready) in_vld_q <= req_i.valid;
      if (adv)         out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_func_q <= req_i.func;
      in_ts_q   <= req_i.timestamp;
    end
    if (fire) res_q <= res_d;
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.captured       = res_q.captured;
  assign res_o.overrange      = res_q.overrange;
  assign res_o.high_count     = res_q.high_count;
  assign res_o.low_count      = res_q.low_count;
  assign res_o.period_count   = res_q.period_count;
  assign res_o.edge_phase     = res_q.edge_phase;
  assign res_o.expect_falling = res_q.expect_falling;

  // a finished measurement and an overrange exclude each other
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.captured && res_o.overrange))
    else $error("captured and overrange both set");

  // counts read zero unless a measurement is held
  a_counts_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.captured) |-> (res_o.high_count == 16'd0 &&
      res_o.low_count == 16'd0 && res_o.period_count == 16'd0))
    else $error("nonzero count without capture");

  a_phase_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.edge_phase != 2'd0))
    else $error("edge phase zero");

  // a request waiting behind a stalled result is not dropped
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> in_vld_q)
    else $error("pending request lost during stall");

endmodule

`default_nettype wire

// ===== test/pulse_period_capture_tb.sv =====
// self-checking testbench for the pulse/period capture block
`default_nettype none

module pulse_period_capture_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppc_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] stamp;
  } capture_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ppc_in_if  req_if ();
  ppc_out_if res_if ();

  pulse_period_capture uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // event requests waiting to be driven and measurements still to come back
  capture_event_t event_q[$];
  result_t        measure_q[$];

  int errors = 0;
  int idle_pct = 0;
  int req_gap = 0;
  int res_stall = 0;
  bit req_taken = 1'b0;

  // mirror of the measurement state and the two registers
  logic        cfg_period;
  logic        cfg_falling_start;
  logic [15:0] stamp_a;
  logic [15:0] stamp_b;
  logic [1:0]  phase_q;
  logic        await_falling;
  logic        done_q;
  logic        overrange_q;
  logic [1:0]  overflows;
  logic [15:0] high_hold;
  logic [15:0] low_hold;

  function automatic void clear_measurement();
    stamp_a = '0;
    stamp_b = '0;
    phase_q = PHASE_ONE;
    await_falling = cfg_falling_start;
    done_q = 1'b0;
    overrange_q = 1'b0;
    overflows = '0;
    high_hold = '0;
    low_hold = '0;
  endfunction

  // elapsed ticks with at most one timer wrap, saturating
  function automatic logic [15:0] lap_ticks(logic [15:0] from_t, logic [15:0] to_t,
                                            logic [1:0] tally);
    if (tally != 2'd0 && to_t >= from_t) return COUNT_MAX;
    return to_t - from_t;
  endfunction

  function automatic result_t measure_step(logic [1:0] fn, logic [15:0] ts);
    result_t r;
    logic [15:0] d;
    logic [16:0] sum;
    logic busy;
    busy = done_q || overrange_q;
    if (fn == FUNC_EDGE && !busy) begin
      if (phase_q == PHASE_TWO) begin
        d = lap_ticks(stamp_a, ts, overflows);
        stamp_b = ts;
        high_hold = '0;
        low_hold = '0;
        // awaiting falling means the first edge was rising: first interval is high
        if (await_falling) high_hold = d;
        else low_hold = d;
        if (!cfg_period) begin
          done_q = 1'b1;
          phase_q = PHASE_ONE;
        end else begin
          phase_q = PHASE_THREE;
        end
      end else if (phase_q == PHASE_THREE) begin
        d = lap_ticks(stamp_b, ts, overflows);
        if (await_falling) high_hold = d;
        else low_hold = d;
        done_q = 1'b1;
        phase_q = PHASE_ONE;
      end else begin
        stamp_a = ts;
        phase_q = PHASE_TWO;
      end
      overflows = '0;
      await_falling = ~await_falling;
    end else if (fn == FUNC_TICK && !busy && phase_q > PHASE_ONE) begin
      overflows = overflows + 2'd1;
      if (overflows >= TALLY_MAX) begin
        overflows = TALLY_MAX;
        overrange_q = 1'b1;
        high_hold = '0;
        low_hold = '0;
        phase_q = PHASE_ONE;
        await_falling = cfg_falling_start;
      end
    end else if (fn == FUNC_REARM) begin
      clear_measurement();
    end
    r.captured = done_q;
    r.overrange = overrange_q;
    r.high_count = done_q ? high_hold : 16'd0;
    r.low_count = done_q ? low_hold : 16'd0;
    sum = {1'b0, r.high_count} + {1'b0, r.low_count};
    r.period_count = sum[16] ? COUNT_MAX : sum[15:0];
    r.edge_phase = (phase_q == 2'd0) ? PHASE_ONE : phase_q;
    r.expect_falling = await_falling;
    return r;
  endfunction

  task automatic flag_error(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %h actual %h", what, want, got);
  endtask

  // request driver
  always @(negedge clk_i) begin
    capture_event_t ev;
    if (rst_ni && !(req_if.valid && !req_taken)) begin
      req_taken = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (event_q.size() > 0 && $urandom_range(99) < idle_pct) begin
        req_gap = $urandom_range(3);
        req_if.valid <= 1'b0;
      end else if (event_q.size() > 0) begin
        ev = event_q.pop_front();
        req_if.valid <= 1'b1;
        req_if.func <= ev.func;
        req_if.timestamp <= ev.stamp;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_stall > 0) begin
        res_stall--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(99) < idle_pct) begin
        res_stall = $urandom_range(3);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        measure_q.push_back(measure_step(req_if.func, req_if.timestamp));
        req_taken = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        got.captured = res_if.captured;
        got.overrange = res_if.overrange;
        got.high_count = res_if.high_count;
        got.low_count = res_if.low_count;
        got.period_count = res_if.period_count;
        got.edge_phase = res_if.edge_phase;
        got.expect_falling = res_if.expect_falling;
        if (measure_q.size() == 0) begin
          flag_error("unexpected result", 64'd0, 64'(got));
        end else begin
          want = measure_q.pop_front();
          if (got.captured !== want.captured)
            flag_error("captured", 64'(want.captured), 64'(got.captured));
          if (got.overrange !== want.overrange)
            flag_error("overrange", 64'(want.overrange), 64'(got.overrange));
          if (got.high_count !== want.high_count)
            flag_error("high_count", 64'(want.high_count), 64'(got.high_count));
          if (got.low_count !== want.low_count)
            flag_error("low_count", 64'(want.low_count), 64'(got.low_count));
          if (got.period_count !== want.period_count)
            flag_error("period_count", 64'(want.period_count), 64'(got.period_count));
          if (got.edge_phase !== want.edge_phase)
            flag_error("edge_phase", 64'(want.edge_phase), 64'(got.edge_phase));
          if (got.expect_falling !== want.expect_falling)
            flag_error("expect_falling", 64'(want.expect_falling),
                       64'(got.expect_falling));
        end
      end
    end
  end

  task automatic add_event(logic [1:0] fn, logic [15:0] ts);
    capture_event_t ev;
    ev.func = fn;
    ev.stamp = ts;
    event_q.push_back(ev);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (event_q.size() != 0 || req_if.valid || measure_q.size() != 0);
  endtask

  // register write followed by a read back of the same register
  task automatic write_reg(logic idx, logic val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {31'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_EDGE_MODE) begin
      cfg_period = val;
    end else begin
      cfg_falling_start = val;
      if (phase_q <= PHASE_ONE) await_falling = val;
    end
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[0] !== val) flag_error("register read back", 64'(val), 64'(prdata[0]));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic use_period, logic falling_start);
    wait_drained();
    write_reg(REG_EDGE_MODE, use_period);
    write_reg(REG_START_EDGE, falling_start);
  endtask

  // mostly clean measurements with random stamps and overflow placement
  task automatic queue_random(int n_items);
    int added;
    int n_edges;
    int roll;
    logic [15:0] t;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(99) < 15) begin
        add_event(2'($urandom_range(3)), 16'($urandom));
        added++;
      end else begin
        if ($urandom_range(99) < 85) begin
          add_event(FUNC_REARM, 16'($urandom));
          added++;
        end
        n_edges = ($urandom_range(99) < 80) ? (cfg_period ? 3 : 2) : $urandom_range(1, 4);
        t = 16'($urandom);
        for (int e = 0; e < n_edges; e++) begin
          add_event(FUNC_EDGE, t);
          added++;
          roll = $urandom_range(99);
          if (roll < 55) begin
            t = t + (($urandom_range(99) < 70) ? 16'($urandom_range(1, 3000)) : 16'($urandom));
          end else if (roll < 90) begin
            add_event(FUNC_TICK, 16'($urandom));
            added++;
            t = ($urandom_range(99) < 70) ? t - 16'($urandom_range(1, 65535)) : 16'($urandom);
          end else begin
            add_event(FUNC_TICK, 16'($urandom));
            add_event(FUNC_TICK, 16'($urandom));
            added += 2;
          end
        end
      end
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.func = FUNC_EDGE;
    req_if.timestamp = '0;
    res_if.ready = 1'b0;
    cfg_period = 1'b0;
    cfg_falling_start = 1'b0;
    clear_measurement();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // pulse mode, rising start: plain, wrapped across one overflow, saturated, overrange
    idle_pct = 20;
    set_config(1'b0, 1'b0);
    add_event(FUNC_EDGE, 16'd0);
    add_event(FUNC_EDGE, 16'hFFFF);
    add_event(FUNC_EDGE, 16'd7);
    add_event(FUNC_REARM, 16'd0);
    add_event(FUNC_TICK, 16'd0);
    add_event(FUNC_EDGE, 16'd100);
    add_event(FUNC_TICK, 16'd0);
    add_event(FUNC_EDGE, 16'd50);
    add_event(FUNC_REARM, 16'd0);
    add_event(FUNC_EDGE, 16'd10);
    add_event(FUNC_TICK, 16'd0);
    add_event(FUNC_EDGE, 16'd20);
    add_event(FUNC_REARM, 16'd0);
    add_event(FUNC_EDGE, 16'd5);
    add_event(FUNC_TICK, 16'd0);
    add_event(FUNC_TICK, 16'd0);
    add_event(FUNC_EDGE, 16'd9);
    add_event(FUNC_SPARE, 16'hA5A5);
    add_event(FUNC_REARM, 16'd0);

    // period mode, falling start: saturated first interval and saturated period
    set_config(1'b1, 1'b1);
    add_event(FUNC_EDGE, 16'd1000);
    add_event(FUNC_TICK, 16'd0);
    add_event(FUNC_EDGE, 16'd3000);
    add_event(FUNC_EDGE, 16'd3500);
    add_event(FUNC_REARM, 16'd0);
    add_event(FUNC_EDGE, 16'd200);
    // mode and start polarity changed while phase two is awaited
    set_config(1'b0, 1'b0);
    add_event(FUNC_EDGE, 16'd700);
    add_event(FUNC_REARM, 16'd0);
    add_event(FUNC_EDGE, 16'd5);
    wait_drained();
    write_reg(REG_EDGE_MODE, 1'b1);
    add_event(FUNC_EDGE, 16'd15);
    // back to pulse mode while phase three is awaited
    wait_drained();
    write_reg(REG_EDGE_MODE, 1'b0);
    add_event(FUNC_EDGE, 16'd40);

    for (int blk = 0; blk < 8; blk++) begin
      case (blk)
        0: set_config(1'b0, 1'b0);
        1: set_config(1'b1, 1'b1);
        2: set_config(1'b1, 1'b0);
        3: set_config(1'b0, 1'b1);
        default: set_config(1'($urandom), 1'($urandom));
      endcase
      idle_pct = (blk % 3 == 0) ? 0 : ((blk % 3 == 1) ? 20 : 50);
      queue_random(125);
    end

    // closing stretch at full rate
    set_config(1'b1, 1'b0);
    idle_pct = 0;
    queue_random(100);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && measure_q.size() == 0) begin
      $display("pulse_period_capture test passed");
    end else begin
      $display("pulse_period_capture test failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("pulse_period_capture test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/ppc_pkg.sv
rtl/ppc_if.sv
rtl/ppc_cfg.sv
rtl/ppc_state.sv
rtl/pulse_period_capture.sv
test/pulse_period_capture_tb.sv
